// ===== hw/rtl/lzwd_pkg.sv =====
// lzwd_pkg: shared types and constants for the 12-bit code stream decoder
// no dependencies
package lzwd_pkg;
   localparam int DictEntries = 4096;
   localparam int MaxString   = 64;
   localparam int CodeW       = 12;
   localparam int LenW        = 7;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOOK  = 8'b0000_0010,
      ST_LWAIT = 8'b0000_0100,
      ST_WALK  = 8'b0000_1000,
      ST_WWAIT = 8'b0001_0000,
      ST_ADD   = 8'b0010_0000,
      ST_EMIT  = 8'b0100_0000,
      ST_CLEAR = 8'b1000_0000
   } state_type;
endpackage

// ===== hw/rtl/lzwd_ram.sv =====
// lzwd_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module lzwd_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/lzw_decoder_12bit.sv =====
// lzw_decoder_12bit: top level of the 12-bit code stream decoder
// depends on lzwd_pkg and lzwd_ram
//
// Two of every three bytes complete a 12-bit code. The IDLE state accepts the
// byte and the LOOK state looks up the code. The prefix chain is walked in the
// WALK state, with a WWAIT state between entries, because the single dictionary
// read port has a registered read. The ADD state adds the new entry and the EMIT
// state first primes the reverse stack. The bytes are then played out at one per
// cycle while the receiver is ready, and the EMIT state then retires the last
// byte. An unknown code gives a single error transaction. After reset, and after
// each end of stream, a clearing pass over all DICT_ENTRIES entries rewrites the
// dictionary before the first byte is taken.
module lzw_decoder_12bit #(
   parameter int DICT_ENTRIES = lzwd_pkg::DictEntries,
   parameter int MAX_STRING   = lzwd_pkg::MaxString
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // code_error
);
   localparam int AW = $clog2(DICT_ENTRIES);
   localparam int SW = $clog2(MAX_STRING);
   localparam int CW = lzwd_pkg::CodeW;
   localparam int LW = lzwd_pkg::LenW;
   localparam int EW = CW + 8 + 8 + LW;

   lzwd_pkg::state_type state_ff, state_in;
   logic [AW:0]   nfc_ff, nfc_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic          havep_ff, havep_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic          eos_ff, eos_in;
   logic [CW-1:0] code_ff, code_in;
   logic          kwk_ff, kwk_in;
   logic [AW-1:0] k_ff, k_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic [7:0]    pfirst_ff, pfirst_in;
   logic [7:0]    cfirst_ff, cfirst_in;
   logic          first_ff, first_in;
   logic          ovalid_ff, ovalid_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic          olast_ff, olast_in;
   logic          oerr_ff, oerr_in;
   logic [AW:0]   clr_ff, clr_in;

   logic          d_we;
   logic [AW-1:0] d_wa, d_ra;
   logic [EW-1:0] d_wd, d_rd;
   logic [CW-1:0] e_prefix;
   logic [7:0]    e_char, e_first;
   logic [LW-1:0] e_len;
   logic          s_we;
   logic [SW-1:0] s_wa, s_ra;
   logic [7:0]    s_wd, s_rd;

   lzwd_ram #(.Width(EW), .Depth(DICT_ENTRIES)) u_dict (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra), .rd_data(d_rd));
   lzwd_ram #(.Width(8), .Depth(MAX_STRING)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));

   assign {e_prefix, e_char, e_first, e_len} = d_rd;

   // dictionary entries below 256 are the single bytes, never stored
   logic          rd_lit_ff;
   logic [7:0]    rd_litv_ff;
   logic [CW-1:0] r_prefix;
   logic [7:0]    r_char, r_first;
   logic [LW-1:0] r_len;
   always_comb begin
      if (rd_lit_ff) begin
         r_prefix = '0; r_char = rd_litv_ff; r_first = rd_litv_ff; r_len = LW'(1);
      end else begin
         r_prefix = e_prefix; r_char = e_char; r_first = e_first; r_len = e_len;
      end
   end

   logic [CW-1:0] new_code;
   logic          can_add, code_known;
   logic [LW-1:0] eff_len;
   assign new_code = (phase_ff == 2'd1) ? {req_tdata[3:0], held_ff}
                                        : {req_tdata, held_ff[7:4]};
   assign can_add = havep_ff && (nfc_ff < (AW+1)'(DICT_ENTRIES)) &&
                    ({1'b0, plen_ff} + 8'd1 <= 8'(MAX_STRING));
   assign code_known = ({1'b0, code_ff} < 13'(nfc_ff)) &&
                       ({1'b0, code_ff} < 13'(DICT_ENTRIES));
   assign eff_len = (r_len > LW'(MAX_STRING)) ? LW'(MAX_STRING) : r_len;

   always_comb begin
      state_in = state_ff; nfc_in = nfc_ff; prev_in = prev_ff; havep_in = havep_ff;
      phase_in = phase_ff; held_in = held_ff; eos_in = eos_ff; code_in = code_ff;
      kwk_in = kwk_ff; k_in = k_ff; len_in = len_ff; idx_in = idx_ff;
      plen_in = plen_ff; pfirst_in = pfirst_ff; cfirst_in = cfirst_ff;
      first_in = first_ff; ovalid_in = ovalid_ff; obyte_in = obyte_ff;
      olast_in = olast_ff; oerr_in = oerr_ff; clr_in = clr_ff;
      d_we = 1'b0; d_wa = nfc_ff[AW-1:0]; d_wd = '0; d_ra = k_ff;
      s_we = 1'b0; s_wa = '0; s_wd = r_char; s_ra = idx_ff[SW-1:0];
      req_tready = 1'b0;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         lzwd_pkg::ST_CLEAR: begin
            d_we = 1'b1; d_wa = clr_ff[AW-1:0]; d_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DICT_ENTRIES - 1)) state_in = lzwd_pkg::ST_IDLE;
         end
         lzwd_pkg::ST_IDLE: begin
            req_tready = !ovalid_ff;
            if (req_tvalid && req_tready) begin
               eos_in = req_tlast;
               if (phase_ff == 2'd1 || phase_ff == 2'd2) begin
                  code_in = new_code;
                  if (phase_ff == 2'd1) begin held_in = req_tdata; phase_in = 2'd2; end
                  else phase_in = 2'd0;
                  state_in = lzwd_pkg::ST_LOOK;
               end else begin
                  held_in = req_tdata; phase_in = 2'd1;
                  if (req_tlast) state_in = lzwd_pkg::ST_EMIT; // reset path
               end
            end
         end
         lzwd_pkg::ST_LOOK: begin
            if (code_known) begin
               kwk_in = 1'b0; k_in = code_ff[AW-1:0]; state_in = lzwd_pkg::ST_LWAIT;
            end else if ({1'b0, code_ff} == 13'(nfc_ff) && can_add) begin
               kwk_in = 1'b1; k_in = prev_ff[AW-1:0]; state_in = lzwd_pkg::ST_LWAIT;
            end else begin
               havep_in = 1'b0;
               ovalid_in = 1'b1; obyte_in = '0; olast_in = 1'b0; oerr_in = 1'b1;
               state_in = lzwd_pkg::ST_EMIT; len_in = '0; idx_in = '0;
            end
            first_in = 1'b1;
         end
         lzwd_pkg::ST_LWAIT: begin
            state_in = lzwd_pkg::ST_WALK;
         end
         lzwd_pkg::ST_WALK: begin
            if (first_ff) begin
               len_in = eff_len; idx_in = eff_len - 1'b1; cfirst_in = r_first;
               s_wa = SW'(eff_len - 1'b1);
               first_in = 1'b0;
            end else begin
               s_wa = idx_ff[SW-1:0] - 1'b1;
               idx_in = idx_ff - 1'b1;
            end
            s_we = 1'b1;
            k_in = ({1'b0, r_prefix} >= 13'(DICT_ENTRIES)) ? '0 : r_prefix[AW-1:0];
            if ((first_ff && eff_len == LW'(1)) || (!first_ff && idx_ff == LW'(1)))
               state_in = lzwd_pkg::ST_ADD;
            else state_in = lzwd_pkg::ST_WWAIT;
         end
         lzwd_pkg::ST_WWAIT: begin
            state_in = lzwd_pkg::ST_WALK;
         end
         lzwd_pkg::ST_ADD: begin
            if (oerr_ff) begin
               state_in = lzwd_pkg::ST_EMIT;
            end else begin
               // kwkwk: append first byte of the previous string
               if (kwk_ff) begin
                  s_we = 1'b1; s_wa = SW'(len_ff); s_wd = cfirst_ff;
                  len_in = len_ff + 1'b1;
               end
               if (can_add) begin
                  d_we = 1'b1;
                  d_wd = {prev_ff, kwk_ff ? cfirst_ff : cfirst_ff, pfirst_ff,
                          plen_ff + 1'b1};
                  nfc_in = nfc_ff + 1'b1;
               end
               prev_in = code_ff; havep_in = 1'b1;
               plen_in = kwk_ff ? len_ff + 1'b1 : len_ff;
               pfirst_in = kwk_ff ? pfirst_ff : cfirst_ff;
               idx_in = '0; s_ra = '0;
               state_in = lzwd_pkg::ST_EMIT; first_in = 1'b1;
            end
         end
         lzwd_pkg::ST_EMIT: begin
            if (oerr_ff || len_ff == '0) begin
               if (!ovalid_ff || rsp_tready) begin
                  oerr_in = 1'b0; len_in = '0;
                  state_in = eos_ff ? lzwd_pkg::ST_CLEAR : lzwd_pkg::ST_IDLE;
                  if (eos_ff) begin
                     nfc_in = (AW+1)'(256); prev_in = '0; havep_in = 1'b0;
                     phase_in = '0; held_in = '0; clr_in = '0; eos_in = 1'b0;
                  end
               end
            end else if (first_ff) begin
               first_in = 1'b0; idx_in = LW'(1); s_ra = '0;
            end else if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1; obyte_in = s_rd;
               olast_in = (idx_ff == len_ff);
               if (idx_ff == len_ff) len_in = '0;
               idx_in = idx_ff + 1'b1; s_ra = SW'(idx_ff);
               first_in = 1'b0;
            end else s_ra = SW'(idx_ff - 1'b1);
         end
         default: state_in = lzwd_pkg::ST_IDLE;
      endcase
      // the first-char of a kwkwk code equals the previous first char
      if (state_ff == lzwd_pkg::ST_WALK && first_ff && kwk_ff) cfirst_in = r_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwd_pkg::ST_CLEAR; nfc_ff <= (AW+1)'(256); prev_ff <= '0;
         havep_ff <= 1'b0; phase_ff <= '0; held_ff <= '0; eos_ff <= 1'b0;
         ovalid_ff <= 1'b0; oerr_ff <= 1'b0; clr_ff <= '0; len_ff <= '0;
         first_ff <= 1'b0; plen_ff <= LW'(1); pfirst_ff <= '0;
      end else begin
         state_ff <= state_in; nfc_ff <= nfc_in; prev_ff <= prev_in;
         havep_ff <= havep_in; phase_ff <= phase_in; held_ff <= held_in;
         eos_ff <= eos_in; ovalid_ff <= ovalid_in; oerr_ff <= oerr_in;
         clr_ff <= clr_in; len_ff <= len_in; first_ff <= first_in;
         plen_ff <= plen_in; pfirst_ff <= pfirst_in;
      end
      code_ff <= code_in; kwk_ff <= kwk_in; k_ff <= k_in; idx_ff <= idx_in;
      cfirst_ff <= cfirst_in; obyte_ff <= obyte_in; olast_ff <= olast_in;
      rd_lit_ff <= (d_ra < AW'(256)); rd_litv_ff <= d_ra[7:0];
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = obyte_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = oerr_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == lzwd_pkg::ST_IDLE) else $error("ready while busy");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0 && !rsp_tlast)
      else $error("error item carries data");
   a_nfc_range: assert property (@(posedge clock) disable iff (reset)
      nfc_ff <= (AW+1)'(DICT_ENTRIES) && nfc_ff >= (AW+1)'(256))
      else $error("next free code out of range");
endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for lzw_decoder_12bit (12-bit code stream decoder)
// depends on lzwd_pkg and the decoder rtl; streams of packed codes are decoded by a
// local dictionary model and every output byte is compared in order
`timescale 1ns / 1ps

module testbench;
   localparam int DictEntries = lzwd_pkg::DictEntries;
   localparam int MaxString   = lzwd_pkg::MaxString;
   localparam int IdleLimit = 20000;
   localparam int LongHold  = 400;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } in_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } out_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // data_byte
   logic       req_tlast = 1'b0;   // end_of_stream
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // out_byte
   logic       rsp_tlast;          // last_of_run
   logic       rsp_tuser;          // code_error

   lzw_decoder_12bit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   in_item_type  byte_queue[$];
   out_item_type decoded_expect[$];
   int        mismatches = 0;
   int        bytes_in = 0, bytes_out = 0, errors_seen = 0, streams_sent = 0;

   // dictionary model
   logic [11:0] dict_prefix[DictEntries];
   logic [7:0]  dict_char[DictEntries];
   logic [7:0]  dict_first[DictEntries];
   int          dict_len[DictEntries];
   int          free_code, last_code, code_phase;
   bit          last_valid;
   logic [7:0]  saved_byte;

   function automatic void dict_clear();
      for (int i = 0; i < DictEntries; i++) begin
         dict_prefix[i] = '0;
         dict_char[i] = (i < 256) ? i[7:0] : 8'd0;
         dict_first[i] = (i < 256) ? i[7:0] : 8'd0;
         dict_len[i] = (i < 256) ? 1 : 0;
      end
      free_code = 256;
      last_code = 0;
      last_valid = 0;
      code_phase = 0;
      saved_byte = 8'd0;
   endfunction

   function automatic bit entry_ok();
      return last_valid && free_code < DictEntries && dict_len[last_code] + 1 <= MaxString;
   endfunction

   function automatic void add_word(logic [7:0] ch);
      dict_prefix[free_code] = last_code[11:0];
      dict_char[free_code] = ch;
      dict_first[free_code] = dict_first[last_code];
      dict_len[free_code] = dict_len[last_code] + 1;
      free_code++;
   endfunction

   function automatic void decode_word(int code);
      logic [7:0] chars[MaxString + 1];
      int n, k;
      out_item_type o;
      if (code < free_code) begin
         n = dict_len[code] > MaxString ? MaxString : dict_len[code];
         k = code;
      end else if (code == free_code && entry_ok()) begin
         n = dict_len[last_code] > MaxString ? MaxString : dict_len[last_code];
         k = last_code;
      end else begin
         last_valid = 0;
         o = '{data: 8'd0, last: 1'b0, err: 1'b1};
         decoded_expect.push_back(o);
         return;
      end
      for (int i = n; i > 0; i--) begin
         chars[i - 1] = dict_char[k];
         k = dict_prefix[k];
      end
      if (code == free_code) begin
         chars[n] = chars[0];
         n++;
         add_word(chars[0]);
      end else if (entry_ok()) begin
         add_word(dict_first[code]);
      end
      last_code = code;
      last_valid = 1;
      for (int i = 0; i < n; i++) begin
         o = '{data: chars[i], last: (i == n - 1), err: 1'b0};
         decoded_expect.push_back(o);
      end
   endfunction

   function automatic void decoder_step(in_item_type it);
      if (code_phase == 1) begin
         decode_word({it.data[3:0], saved_byte});
         saved_byte = it.data;
         code_phase = 2;
      end else if (code_phase == 2) begin
         decode_word({it.data, saved_byte[7:4]});
         code_phase = 0;
      end else begin
         saved_byte = it.data;
         code_phase = 1;
      end
      if (it.eos) dict_clear();
   endfunction

   // stream building
   function automatic void push_codes(int codes[$]);
      in_item_type it;
      int n = codes.size();
      int c1;
      for (int i = 0; i < n; i += 2) begin
         c1 = (i + 1 < n) ? codes[i + 1] : $urandom_range(0, 4095);
         it = '{data: codes[i][7:0], eos: 1'b0};
         byte_queue.push_back(it);
         it = '{data: {c1[3:0], codes[i][11:8]}, eos: (i + 1 >= n)};
         byte_queue.push_back(it);
         if (i + 1 < n) begin
            it = '{data: c1[11:4], eos: (i + 2 >= n)};
            byte_queue.push_back(it);
         end
      end
      streams_sent++;
   endfunction

   function automatic void random_stream(int ncodes, int err_pct);
      int codes[$];
      int top = 256, r, c;
      bit prev_ok = 0;
      for (int i = 0; i < ncodes; i++) begin
         r = $urandom_range(0, 99);
         if (r < err_pct) c = $urandom_range(0, 4095);
         else if (r < err_pct + 12 && prev_ok) c = top;
         else if (r < 60 || top == 256) c = $urandom_range(0, 255);
         else c = $urandom_range(256, top - 1);
         prev_ok = (c <= top);
         if (prev_ok && i > 0 && top < DictEntries) top++;
         codes.push_back(c);
      end
      push_codes(codes);
   endfunction

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // driver
   bit req_taken, rsp_taken;
   int req_gap = 0, rsp_gap = 0, hold_left = 0;
   bit quiet_req = 0, quiet_rsp = 0, hold_done = 0;

   always @(negedge clock) begin
      logic          v_next;
      in_item_type   it;
      v_next = req_tvalid;
      it = '{data: req_tdata, eos: req_tlast};
      if (!reset && (!req_tvalid || req_taken)) begin
         v_next = 1'b0;
         if ($urandom_range(0, 49) == 0) quiet_req = ~quiet_req;
         if (req_gap > 0) begin
            req_gap--;
         end else if (byte_queue.size() > 0) begin
            it = byte_queue.pop_front();
            v_next = 1'b1;
            req_gap = quiet_req ? 0 : pick_gap();
         end
      end
      req_tvalid <= v_next;
      req_tdata <= it.data;
      req_tlast <= it.eos;
   end

   // receiver
   always @(negedge clock) begin
      logic r_next;
      r_next = 1'b0;
      if (!reset) begin
         if (!hold_done && bytes_in >= 60) begin
            hold_done = 1;
            hold_left = LongHold;
         end
         if ($urandom_range(0, 49) == 0) quiet_rsp = ~quiet_rsp;
         if (hold_left > 0) begin
            hold_left--;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end else begin
            r_next = 1'b1;
            rsp_gap = quiet_rsp ? 0 : pick_gap();
         end
      end
      rsp_tready <= r_next;
   end

   // monitor
   int idle_cycles = 0;
   always @(posedge clock) begin
      out_item_type want;
      req_taken = 0;
      rsp_taken = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1;
            bytes_in++;
            decoder_step('{data: req_tdata, eos: req_tlast});
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1;
            bytes_out++;
            if (rsp_tuser) errors_seen++;
            if (decoded_expect.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, 8'd0);
            end else begin
               want = decoded_expect.pop_front();
               if (rsp_tdata !== want.data) report_mismatch("out_byte", rsp_tdata, want.data);
               if (rsp_tlast !== want.last) report_mismatch("last_of_run", rsp_tlast, want.last);
               if (rsp_tuser !== want.err) report_mismatch("code_error", rsp_tuser, want.err);
            end
         end
         idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("timeout: no transaction for %0d cycles", IdleLimit);
            $display("lzw_decoder_12bit test failed");
            $finish;
         end
      end
   end

   initial begin
      int codes[$];
      dict_clear();
      // extremes: code zero, highest code (unknown)
      push_codes('{0, 4095});
      // repeat-pattern case with no previous code, then valid repeat-pattern codes
      push_codes('{256, 255, 256, 257, 258, 300});
      // lone byte at end of stream is dropped
      byte_queue.push_back('{data: 8'hA5, eos: 1'b1});
      streams_sent++;
      // two bytes complete one code, third would be partial
      push_codes('{65, 66, 256, 4095, 258});
      // strings grow to the length limit, then the next repeat-pattern code is refused
      codes = '{97};
      for (int i = 0; i < MaxString; i++) codes.push_back(256 + i);
      push_codes(codes);
      random_stream(4, 10);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (byte_queue.size() == 0 && !req_tvalid);
      wait (decoded_expect.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d streams, %0d bytes in; %0d results checked, %0d of them errors",
               streams_sent, bytes_in, bytes_out, errors_seen);
      if (mismatches == 0 && decoded_expect.size() == 0) begin
         $display("lzw_decoder_12bit test passed");
      end else begin
         $display("lzw_decoder_12bit test failed");
      end
      $finish;
   end
endmodule
